### hw/rtl/swtm_pkg.sv
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared types and constants of the sliding-window trimmed mean filter.
// ----------------------------------------------------------------------------
package swtm_pkg;

	localparam int DATA_W           = 16;
	localparam int COUNT_W          = 4;
	localparam int WINDOW_DEPTH_DEF = 8;

	// At this many samples or more the minimum and maximum are dropped.
	localparam int TRIM_MIN_COUNT   = 3;
	// Number of samples removed by trimming.
	localparam int TRIM_DROP        = 2;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t                   opcode;
		logic signed [DATA_W-1:0]  sample_watts;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  mean_watts;
		logic        [COUNT_W-1:0] sample_count;
	} out_item_t;

	// Handshake between the sequencer and the serial divider.
	typedef struct packed {
		logic start;
		logic done;
	} div_ctrl_t;

endpackage

### hw/rtl/sliding_window_trimmed_mean_top.sv
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_top
// Trimmed mean over a sliding window of signed grid-power samples.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, in_item) takes one item at a time.
// A push item stores its sample in the window, overwriting the oldest sample
// once WINDOW_DEPTH samples are held, and a clear item empties the window.
// Every item produces exactly one result item on the output channel
// (out_valid, out_ready, out_item): the trimmed mean and the new fill count.
//
// A push goes through these steps in order from acceptance to result: it
// writes the sample, streams the window out of the single read port for
// sum, minimum and maximum, trims, divides in the serial divider over the
// full sum width, and loads the output register. A clear goes straight to
// loading the output register.
// in_ready is high only while no item is at work.
//
// The result sits in an output register. While the receiver stalls, the
// next item is still accepted and computed; it then waits until the output
// register is taken. Reset empties the window and drops any pending result;
// the sample memory itself is not cleared, since only written entries are read.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_top #(
	parameter int WINDOW_DEPTH = swtm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swtm_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output swtm_pkg::out_item_t out_item
);
	import swtm_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = DATA_W + CNT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_SCAN,
		S_PREP,
		S_DIV,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         fill_q;
	logic [PTR_W-1:0]         oldest_q;
	logic signed [DATA_W-1:0] sample_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [CNT_W-1:0]         rd_left_q;
	logic                     rd_vld_s1;
	logic                     first_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [DATA_W-1:0] lo_q;
	logic signed [DATA_W-1:0] hi_q;
	logic signed [DATA_W-1:0] mean_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic                     full;
	logic [CNT_W:0]           wsum;
	logic [CNT_W:0]           wadj;
	logic [PTR_W-1:0]         waddr;
	logic                     mem_we;
	logic                     mem_re;
	logic signed [DATA_W-1:0] rdata;
	logic signed [SUM_W-1:0]  rdata_ext;
	logic signed [SUM_W-1:0]  dividend;
	logic [CNT_W-1:0]         divisor;
	logic signed [SUM_W-1:0]  quotient;
	div_ctrl_t                div_req;
	div_ctrl_t                div_rsp;
	logic [CNT_W+COUNT_W-1:0] count_ext;
	logic                     out_free;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(WINDOW_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	// Write position: the oldest slot when full, else the first free slot.
	assign full  = (fill_q == CNT_W'(WINDOW_DEPTH));
	assign wsum  = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(fill_q);
	assign wadj  = (wsum >= (CNT_W+1)'(WINDOW_DEPTH)) ? wsum - (CNT_W+1)'(WINDOW_DEPTH) : wsum;
	assign waddr = full ? oldest_q : wadj[PTR_W-1:0];

	assign mem_we = (state_q == S_WRITE);
	assign mem_re = (state_q == S_SCAN) && (rd_left_q != '0);

	swtm_window_ram #(
		.DEPTH  (WINDOW_DEPTH),
		.ADDR_W (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (sample_q),
		.re    (mem_re),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	assign rdata_ext = {{(SUM_W-DATA_W){rdata[DATA_W-1]}}, rdata};

	// With fewer than three samples the plain mean is taken, else the
	// minimum and maximum are removed from both sum and count.
	always_comb begin
		if (fill_q < CNT_W'(TRIM_MIN_COUNT)) begin
			dividend = sum_q;
			divisor  = fill_q;
		end else begin
			dividend = sum_q - {{(SUM_W-DATA_W){lo_q[DATA_W-1]}}, lo_q}
			                 - {{(SUM_W-DATA_W){hi_q[DATA_W-1]}}, hi_q};
			divisor  = fill_q - CNT_W'(TRIM_DROP);
		end
	end

	assign div_req.start = (state_q == S_PREP);
	assign div_req.done  = 1'b0;

	swtm_divider #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (div_req),
		.ctrl_out (div_rsp),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign count_ext = (CNT_W+COUNT_W)'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			oldest_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			// A result taken while the next one is loaded is handled below.
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_item.opcode == OP_CLEAR) begin
							fill_q   <= '0;
							oldest_q <= '0;
							mean_q   <= '0;
							state_q  <= S_DONE;
						end else begin
							sample_q <= in_item.sample_watts;
							state_q  <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					if (full) begin
						oldest_q  <= ptr_inc(oldest_q);
						rd_ptr_q  <= ptr_inc(oldest_q);
						rd_left_q <= fill_q;
					end else begin
						fill_q    <= fill_q + 1'b1;
						rd_ptr_q  <= oldest_q;
						rd_left_q <= fill_q + 1'b1;
					end
					first_q <= 1'b1;
					sum_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (mem_re) begin
						rd_ptr_q  <= ptr_inc(rd_ptr_q);
						rd_left_q <= rd_left_q - 1'b1;
					end
					if (rd_vld_s1) begin
						sum_q   <= sum_q + rdata_ext;
						first_q <= 1'b0;
						if (first_q || rdata < lo_q) begin
							lo_q <= rdata;
						end
						if (first_q || rdata > hi_q) begin
							hi_q <= rdata;
						end
					end else if (rd_left_q == '0) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						mean_q  <= quotient[DATA_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q.mean_watts   <= mean_q;
						out_q.sample_count <= count_ext[COUNT_W-1:0];
						out_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// The fill count never exceeds the window and the pointer stays in range.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("fill count above window depth");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q <= PTR_W'(WINDOW_DEPTH - 1))
		else $error("oldest pointer out of range");

	// A clear item leaves an empty window behind it.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.opcode == OP_CLEAR) |=> (fill_q == '0))
		else $error("clear did not empty the window");

	// Read data only returns while the window is being scanned.
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("window read data outside scan");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

endmodule

### hw/rtl/swtm_window_ram.sv
// ----------------------------------------------------------------------------
// swtm_window_ram
// Sample window storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swtm_window_ram #(
	parameter int DEPTH  = swtm_pkg::WINDOW_DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [ADDR_W-1:0]                 waddr,
	input  logic signed [swtm_pkg::DATA_W-1:0] wdata,
	input  logic                              re,
	input  logic [ADDR_W-1:0]                 raddr,
	output logic signed [swtm_pkg::DATA_W-1:0] rdata
);
	import swtm_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/swtm_divider.sv
// ----------------------------------------------------------------------------
// swtm_divider
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module swtm_divider #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swtm_pkg::div_ctrl_t     ctrl_in,
	output swtm_pkg::div_ctrl_t     ctrl_out,
	input  logic signed [NUM_W-1:0] dividend,
	input  logic        [DEN_W-1:0] divisor,
	output logic signed [NUM_W-1:0] quotient
);
	import swtm_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, mag_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// The last quotient bit lands at the edge that raises done.
			done_q <= busy_q && !ctrl_in.start && (cnt_q == CNT_W'(1));
			if (ctrl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_in.start) begin
			// Work on the magnitude; the sign is put back at the end.
			mag_q <= dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[NUM_W-1];
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			mag_q <= {mag_q[NUM_W-2:0], ge};
		end
	end

	assign quotient       = neg_q ? -$signed(mag_q) : $signed(mag_q);
	assign ctrl_out.start = 1'b0;
	assign ctrl_out.done  = done_q;

endmodule
